@@ rtl/sls_pkg.sv @@
package sls_pkg;

  // number of bitmap rows in one sprite copy (1 to 16)
  localparam int unsigned SpriteRows = 10;

  // phase encoding: wait, first copy rows, gap load, gap count, duplicate rows
  localparam int unsigned PhaseW = $clog2(2 * SpriteRows + 4);

  localparam logic [PhaseW-1:0] PhWait      = PhaseW'(0);
  localparam logic [PhaseW-1:0] PhFirstRow  = PhaseW'(1);
  localparam logic [PhaseW-1:0] PhGapLoad   = PhaseW'(SpriteRows + 1);
  localparam logic [PhaseW-1:0] PhGapCount  = PhaseW'(SpriteRows + 2);
  localparam logic [PhaseW-1:0] PhDupFirst  = PhaseW'(SpriteRows + 3);
  localparam logic [PhaseW-1:0] PhDupLast   = PhaseW'(2 * SpriteRows + 2);

  localparam int unsigned LineW   = 9;
  localparam int unsigned PosW    = 8;
  localparam int unsigned SizeW   = 2;
  localparam int unsigned RowW    = 4;
  localparam int unsigned RepeatW = 3;

  localparam logic [LineW-1:0] LastLine     = LineW'(269);
  localparam logic [PosW-1:0]  GapNone      = PosW'(255);
  localparam logic [PosW-1:0]  GapStopAbove = PosW'(252);

  localparam logic [RowW-1:0] LastRow = RowW'(SpriteRows - 1);

endpackage

@@ rtl/sprite_line_sequencer_core.sv @@
// stages: an accepted word passes two register stages, input register then result
//   register, before its result word shows at the output
// throughput: one word per cycle unless the output stalls; phase, countdown and
//   repeat update in the single cycle a word moves from input to result register
// reset: rst_ni is asynchronous and active low; it empties both stages and
//   clears phase, line countdown and row repeat to zero (waiting for first copy)
module sprite_line_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sls_pkg::LineW-1:0]     line_number_i,
  input  logic [sls_pkg::PosW-1:0]      first_y_i,
  input  logic [sls_pkg::PosW-1:0]      gap_y_i,
  input  logic [sls_pkg::PosW-1:0]      first_x_i,
  input  logic [sls_pkg::PosW-1:0]      dup_x_i,
  input  logic [sls_pkg::SizeW-1:0]     size_code_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          row_valid_o,
  output logic [sls_pkg::RowW-1:0]      row_index_o,
  output logic [sls_pkg::PosW-1:0]      x_start_o,
  output logic                          is_duplicate_o,
  output logic                          finished_pulse_o
);

  // ---------------------------------------------------------------------------
  // input register stage
  // ---------------------------------------------------------------------------
  logic                         s1_valid_q;
  logic [sls_pkg::LineW-1:0]    s1_line_q;
  logic [sls_pkg::PosW-1:0]     s1_first_y_q;
  logic [sls_pkg::PosW-1:0]     s1_gap_y_q;
  logic [sls_pkg::PosW-1:0]     s1_first_x_q;
  logic [sls_pkg::PosW-1:0]     s1_dup_x_q;
  logic [sls_pkg::SizeW-1:0]    s1_size_q;

  // sequencer state
  logic [sls_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic [sls_pkg::PosW-1:0]     countdown_q, countdown_d;
  logic [sls_pkg::RepeatW-1:0]  repeat_q, repeat_d;

  // result register stage
  logic                         out_valid_q;
  logic                         row_valid_q, row_valid_d;
  logic [sls_pkg::RowW-1:0]     row_index_q, row_index_d;
  logic [sls_pkg::PosW-1:0]     x_start_q, x_start_d;
  logic                         dup_q, dup_d;
  logic                         fin_q, fin_d;

  logic s1_late;       // line beyond the visible area: no result, state held
  logic out_free;      // result register can take a word this cycle
  logic s1_fire;       // word leaves the input register this cycle

  assign s1_late    = s1_line_q > sls_pkg::LastLine;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (s1_late || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // ---------------------------------------------------------------------------
  // per-line sequencing
  // ---------------------------------------------------------------------------
  logic [sls_pkg::RowW-1:0]    size_lines;   // 2^size_code lines per row
  logic [sls_pkg::RowW-1:0]    repeat_inc;
  logic                        row_done;     // current row used up its lines
  logic [sls_pkg::LineW:0]     start_line;   // first_y + 2, one bit wider
  logic [sls_pkg::PosW-1:0]    gap_load;
  logic                        gap_stop;
  logic                        gap_busy;

  always_comb begin
    size_lines = sls_pkg::RowW'(1) << s1_size_q;
    start_line = '0;
    gap_load   = '0;
    gap_stop   = 1'b0;
    gap_busy   = 1'b0;
    repeat_inc = '0;
    row_done   = 1'b0;

    phase_d     = phase_q;
    countdown_d = countdown_q;
    repeat_d    = repeat_q;

    row_valid_d = 1'b0;
    row_index_d = '0;
    x_start_d   = '0;
    dup_d       = 1'b0;
    fin_d       = 1'b0;

    // line zero reloads the sequencer before the line is handled
    if (s1_line_q == '0) begin
      phase_d     = sls_pkg::PhWait;
      countdown_d = s1_first_y_q;
      repeat_d    = '0;
    end

    // wait for the first copy's start line
    start_line = {2'b00, countdown_d} + (sls_pkg::LineW + 1)'(2);
    if (phase_d == sls_pkg::PhWait && {1'b0, s1_line_q} == start_line) begin
      phase_d = sls_pkg::PhFirstRow;
    end

    repeat_inc = {1'b0, repeat_d} + sls_pkg::RowW'(1);

    if (phase_d >= sls_pkg::PhFirstRow && phase_d < sls_pkg::PhGapLoad) begin
      // first copy, row phase-1 at first_x
      row_valid_d = 1'b1;
      row_index_d = sls_pkg::RowW'(phase_d - sls_pkg::PhFirstRow);
      x_start_d   = s1_first_x_q;
      row_done    = repeat_inc >= size_lines;
      if (row_done) begin
        repeat_d = '0;
        phase_d  = phase_d + sls_pkg::PhaseW'(1);
      end else begin
        repeat_d = repeat_inc[sls_pkg::RepeatW-1:0];
      end
      fin_d = (phase_d == sls_pkg::PhGapLoad);
    end else if (phase_d >= sls_pkg::PhGapLoad && phase_d <= sls_pkg::PhDupLast) begin
      // gap load: all-ones means no gap, the few codes below it stop duplicates
      if (phase_d == sls_pkg::PhGapLoad) begin
        gap_load    = (s1_gap_y_q == sls_pkg::GapNone) ? '0
                                                       : s1_gap_y_q + sls_pkg::PosW'(1);
        countdown_d = gap_load;
        gap_stop    = gap_load > sls_pkg::GapStopAbove;
        if (!gap_stop) begin
          repeat_d = '0;
          phase_d  = sls_pkg::PhGapCount;
        end
      end
      // gap countdown, falls into the first duplicate row when it hits zero
      if (!gap_stop && phase_d == sls_pkg::PhGapCount) begin
        if (countdown_d != '0) begin
          countdown_d = countdown_d - sls_pkg::PosW'(1);
          gap_busy    = 1'b1;
        end else begin
          phase_d = sls_pkg::PhDupFirst;
        end
      end
      // duplicate copy at dup_x
      if (!gap_stop && !gap_busy) begin
        row_valid_d = 1'b1;
        row_index_d = sls_pkg::RowW'(phase_d - sls_pkg::PhDupFirst);
        x_start_d   = s1_dup_x_q;
        dup_d       = 1'b1;
        row_done    = repeat_inc >= size_lines;
        if (row_done) begin
          repeat_d = '0;
          phase_d  = phase_d + sls_pkg::PhaseW'(1);
          // last duplicate row done: pulse and go back to the gap load
          if (phase_d > sls_pkg::PhDupLast) begin
            fin_d   = 1'b1;
            phase_d = sls_pkg::PhGapLoad;
          end
        end else begin
          repeat_d = repeat_inc[sls_pkg::RepeatW-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= sls_pkg::PhWait;
      countdown_q <= '0;
      repeat_q    <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      // late lines leave the state untouched
      if (s1_fire && !s1_late) begin
        phase_q     <= phase_d;
        countdown_q <= countdown_d;
        repeat_q    <= repeat_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q && !s1_late;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_line_q    <= line_number_i;
      s1_first_y_q <= first_y_i;
      s1_gap_y_q   <= gap_y_i;
      s1_first_x_q <= first_x_i;
      s1_dup_x_q   <= dup_x_i;
      s1_size_q    <= size_code_i;
    end
    if (s1_fire && !s1_late) begin
      row_valid_q <= row_valid_d;
      row_index_q <= row_index_d;
      x_start_q   <= x_start_d;
      dup_q       <= dup_d;
      fin_q       <= fin_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_valid_o      = row_valid_q;
  assign row_index_o      = row_index_q;
  assign x_start_o        = x_start_q;
  assign is_duplicate_o   = dup_q;
  assign finished_pulse_o = fin_q;

`ifndef SYNTH
  // phase never leaves the used range once out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= sls_pkg::PhDupLast)
    else $error("phase outside used range");

  // an empty line carries zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !row_valid_o |->
      row_index_o == '0 && x_start_o == '0 && !is_duplicate_o && !finished_pulse_o)
    else $error("payload set on a line with no row");

  // the finished pulse only comes with the last row of a copy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_pulse_o |-> row_valid_o && row_index_o == sls_pkg::LastRow)
    else $error("finished pulse off the last row");

  // input side stalls only behind a held word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without cause");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  // one scanline tick as driven on the input channel
  typedef struct packed {
    logic [sls_pkg::LineW-1:0] line;
    logic [sls_pkg::PosW-1:0]  fy;
    logic [sls_pkg::PosW-1:0]  gy;
    logic [sls_pkg::PosW-1:0]  fx;
    logic [sls_pkg::PosW-1:0]  dx;
    logic [sls_pkg::SizeW-1:0] sz;
  } tick_t;

  // one result word: the sprite row shown on a line
  typedef struct packed {
    logic                     shown;
    logic [sls_pkg::RowW-1:0] row;
    logic [sls_pkg::PosW-1:0] xs;
    logic                     dup;
    logic                     fin;
  } row_word_t;

  typedef struct packed {
    tick_t     t;
    bit        typed;
    row_word_t want;
  } plan_row_t;

  localparam bit Typed   = 1'b1;
  localparam bit Derived = 1'b0;

  localparam int RandomWords = 1030;
  localparam int HoldOff     = 64;
  localparam int DrainCycles = 32;
  localparam int PressureAt  = 300;

  // directed lines: reset state, late lines, full first copy at size 1,
  // stopping gap, zero gap, first copy at the latest possible start line, repeats
  localparam int PlanLen = 23;
  localparam plan_row_t Plan [PlanLen] = '{
    '{'{1, 0, 0, 0, 0, 0},                                  Typed,   '0},
    '{'{511, 255, 255, 255, 255, 3},                        Derived, '0},
    '{'{sls_pkg::LastLine + 1, 0, 0, 0, 0, 0},              Derived, '0},
    '{'{0, 0, sls_pkg::GapStopAbove, 255, 0, 0},            Typed,   '0},
    '{'{2, 0, sls_pkg::GapStopAbove, 255, 0, 0},            Typed,   '{1, 0, 255, 0, 0}},
    '{'{3, 0, sls_pkg::GapStopAbove, 255, 0, 0},            Derived, '0},
    '{'{4, 0, sls_pkg::GapStopAbove, 255, 0, 0},            Derived, '0},
    '{'{5, 0, sls_pkg::GapStopAbove, 255, 0, 0},            Derived, '0},
    '{'{6, 0, sls_pkg::GapStopAbove, 255, 0, 0},            Derived, '0},
    '{'{7, 0, sls_pkg::GapStopAbove, 255, 0, 0},            Derived, '0},
    '{'{8, 0, sls_pkg::GapStopAbove, 255, 0, 0},            Derived, '0},
    '{'{9, 0, sls_pkg::GapStopAbove, 255, 0, 0},            Derived, '0},
    '{'{10, 0, sls_pkg::GapStopAbove, 255, 0, 0},           Derived, '0},
    '{'{11, 0, sls_pkg::GapStopAbove, 255, 0, 0},           Typed,
      '{1, sls_pkg::LastRow, 255, 0, 1}},
    '{'{12, 0, sls_pkg::GapStopAbove, 255, 0, 0},           Typed,   '0},
    '{'{13, 0, sls_pkg::GapNone - 1, 255, 0, 0},            Typed,   '0},
    '{'{14, 0, sls_pkg::GapNone, 255, 0, 0},                Typed,   '{1, 0, 0, 1, 0}},
    '{'{sls_pkg::LastLine, 0, sls_pkg::GapNone, 255, 8'hA5, 0}, Derived, '0},
    '{'{0, 255, 0, 8'h5A, 8'hC3, 3},                        Typed,   '0},
    '{'{257, 255, 0, 8'h5A, 8'hC3, 3},                      Typed,   '{1, 0, 8'h5A, 0, 0}},
    '{'{300, 255, 0, 8'h5A, 8'hC3, 3},                      Derived, '0},
    '{'{258, 255, 0, 8'h5A, 8'hC3, 3},                      Derived, '0},
    '{'{0, 10, 7, 8'h0F, 8'hF0, 2},                         Typed,   '0}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [sls_pkg::LineW-1:0] line_number_i;
  logic [sls_pkg::PosW-1:0]  first_y_i;
  logic [sls_pkg::PosW-1:0]  gap_y_i;
  logic [sls_pkg::PosW-1:0]  first_x_i;
  logic [sls_pkg::PosW-1:0]  dup_x_i;
  logic [sls_pkg::SizeW-1:0] size_code_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      row_valid_o;
  logic [sls_pkg::RowW-1:0]  row_index_o;
  logic [sls_pkg::PosW-1:0]  x_start_o;
  logic                      is_duplicate_o;
  logic                      finished_pulse_o;

  sprite_line_sequencer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .line_number_i   (line_number_i),
    .first_y_i       (first_y_i),
    .gap_y_i         (gap_y_i),
    .first_x_i       (first_x_i),
    .dup_x_i         (dup_x_i),
    .size_code_i     (size_code_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .row_valid_o     (row_valid_o),
    .row_index_o     (row_index_o),
    .x_start_o       (x_start_o),
    .is_duplicate_o  (is_duplicate_o),
    .finished_pulse_o(finished_pulse_o)
  );

  // sequencer state mirrored in the bench
  logic [sls_pkg::PhaseW-1:0]  seq_phase;
  logic [sls_pkg::PosW-1:0]    seq_countdown;
  logic [sls_pkg::RepeatW-1:0] seq_repeat;

  row_word_t row_words_due[$];
  int        mismatches;
  int        words_seen;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic flag(input string msg);
    mismatches++;
    $display("%0t: %s", $realtime, msg);
  endtask

  // one more line spent on the current row; true when the row is done
  function automatic bit advance_repeat(input int rep_lines);
    if (int'(seq_repeat) + 1 >= rep_lines) begin
      seq_repeat = '0;
      seq_phase  = seq_phase + sls_pkg::PhaseW'(1);
      return 1'b1;
    end
    seq_repeat = seq_repeat + sls_pkg::RepeatW'(1);
    return 1'b0;
  endfunction

  // works out the row shown on one scanline; false for a line with no word
  function automatic bit next_sprite_row(input tick_t t, output row_word_t r);
    int rep_lines;
    int gap_lines;
    bit idle_line;
    r = '0;
    rep_lines = 1 << t.sz;
    if (t.line == '0) begin
      seq_countdown = t.fy;
      seq_phase     = sls_pkg::PhWait;
      seq_repeat    = '0;
    end
    if (t.line > sls_pkg::LastLine) return 1'b0;

    if (seq_phase == sls_pkg::PhWait && int'(t.line) == int'(seq_countdown) + 2)
      seq_phase = sls_pkg::PhFirstRow;

    if (seq_phase >= sls_pkg::PhFirstRow && seq_phase < sls_pkg::PhGapLoad) begin
      r.shown = 1'b1;
      r.row   = sls_pkg::RowW'(seq_phase - sls_pkg::PhFirstRow);
      r.xs    = t.fx;
      void'(advance_repeat(rep_lines));
      if (seq_phase == sls_pkg::PhGapLoad) r.fin = 1'b1;
    end else if (seq_phase >= sls_pkg::PhGapLoad && seq_phase <= sls_pkg::PhDupLast) begin
      idle_line = 1'b0;
      if (seq_phase == sls_pkg::PhGapLoad) begin
        gap_lines     = (t.gy == sls_pkg::GapNone) ? 0 : int'(t.gy) + 1;
        seq_countdown = sls_pkg::PosW'(gap_lines);
        // stopping gap holds the phase here and rereads gap_y next line
        if (gap_lines > int'(sls_pkg::GapStopAbove)) begin
          idle_line = 1'b1;
        end else begin
          seq_repeat = '0;
          seq_phase  = sls_pkg::PhGapCount;
        end
      end
      if (!idle_line && seq_phase == sls_pkg::PhGapCount) begin
        if (seq_countdown != '0) begin
          seq_countdown = seq_countdown - sls_pkg::PosW'(1);
          idle_line     = 1'b1;
        end else begin
          seq_phase = sls_pkg::PhDupFirst;
        end
      end
      if (!idle_line) begin
        r.shown = 1'b1;
        r.row   = sls_pkg::RowW'(seq_phase - sls_pkg::PhDupFirst);
        r.xs    = t.dx;
        r.dup   = 1'b1;
        if (advance_repeat(rep_lines) && seq_phase > sls_pkg::PhDupLast) begin
          r.fin     = 1'b1;
          seq_phase = sls_pkg::PhGapLoad;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [sls_pkg::PosW-1:0] pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2: return sls_pkg::GapNone;
      3:       return sls_pkg::PosW'($urandom_range(sls_pkg::GapStopAbove,
                                                    sls_pkg::GapNone - 1));
      4:       return sls_pkg::PosW'($urandom_range(0, 255));
      default: return sls_pkg::PosW'($urandom_range(0, 15));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_tick(input tick_t t, input int gap, input bit typed,
                           input row_word_t want);
    row_word_t r;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    line_number_i <= t.line;
    first_y_i     <= t.fy;
    gap_y_i       <= t.gy;
    first_x_i     <= t.fx;
    dup_x_i       <= t.dx;
    size_code_i   <= t.sz;
    do @(posedge clk_i); while (!in_ready_o);
    if (next_sprite_row(t, r)) row_words_due.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  // result side: random stalls, calm stretches, and one long hold-off
  initial begin
    row_word_t got;
    row_word_t want;
    int        hold;
    bit        rx_calm;
    out_ready_i = 1'b0;
    mismatches  = 0;
    words_seen  = 0;
    rx_calm     = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      if (words_seen == PressureAt) hold = HoldOff;
      else hold = rx_calm ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{row_valid_o, row_index_o, x_start_o, is_duplicate_o, finished_pulse_o};
      if (row_words_due.size() == 0) begin
        flag($sformatf("word %0d arrived with no line pending", words_seen));
      end else begin
        want = row_words_due.pop_front();
        if (got.shown !== want.shown)
          flag($sformatf("word %0d row_valid %0b, want %0b", words_seen, got.shown,
                         want.shown));
        if (got.row !== want.row)
          flag($sformatf("word %0d row_index %0d, want %0d", words_seen, got.row,
                         want.row));
        if (got.xs !== want.xs)
          flag($sformatf("word %0d x_start %0d, want %0d", words_seen, got.xs, want.xs));
        if (got.dup !== want.dup)
          flag($sformatf("word %0d is_duplicate %0b, want %0b", words_seen, got.dup,
                         want.dup));
        if (got.fin !== want.fin)
          flag($sformatf("word %0d finished_pulse %0b, want %0b", words_seen, got.fin,
                         want.fin));
      end
      words_seen++;
      @(negedge clk_i);
    end
  end

  // stimulus: directed table, then frames of scanlines with some noise
  initial begin
    tick_t t;
    int    produced;
    int    first_line;
    int    last_line;
    bit    tx_calm;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    line_number_i = '0;
    first_y_i     = '0;
    gap_y_i       = '0;
    first_x_i     = '0;
    dup_x_i       = '0;
    size_code_i   = '0;
    seq_phase     = sls_pkg::PhWait;
    seq_countdown = '0;
    seq_repeat    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < PlanLen; i++)
      send_tick(Plan[i].t, $urandom_range(0, 7), Plan[i].typed, Plan[i].want);

    // every tick counts, late lines too
    produced = 0;
    while (produced < RandomWords) begin
      t.fy = ($urandom_range(0, 9) < 7) ? sls_pkg::PosW'($urandom_range(0, 40))
                                        : sls_pkg::PosW'($urandom_range(0, 255));
      t.gy = pick_gap();
      t.fx = sls_pkg::PosW'($urandom_range(0, 255));
      t.dx = sls_pkg::PosW'($urandom_range(0, 255));
      t.sz = sls_pkg::SizeW'($urandom_range(0, 3));
      tx_calm = ($urandom_range(0, 4) == 0);
      // mostly frames that start at line 0, sometimes one joined midway
      first_line = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 100) : 0;
      if ($urandom_range(0, 4) == 0) last_line = 311;
      else begin
        last_line = int'(t.fy) + $urandom_range(30, 220);
        if (last_line > int'(sls_pkg::LastLine)) last_line = int'(sls_pkg::LastLine);
      end
      for (int ln = first_line; ln <= last_line && produced < RandomWords; ln++) begin
        t.line = sls_pkg::LineW'(ln);
        case ($urandom_range(0, 39))
          0: t.line = sls_pkg::LineW'($urandom_range(sls_pkg::LastLine + 1, 511));
          1: t.line = sls_pkg::LineW'($urandom_range(0, 511));
          2: t.gy = pick_gap();
          3: t.sz = sls_pkg::SizeW'($urandom_range(0, 3));
          default: ;
        endcase
        send_tick(t, tx_calm ? 0 : $urandom_range(0, 7), Derived, '0);
        produced++;
      end
    end
    in_valid_i <= 1'b0;

    while (row_words_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && row_words_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sls_pkg.sv
rtl/sprite_line_sequencer_core.sv
tb/testbench.sv
